// ===== rtl/pc1_pkg.sv =====
// Package for the c1 pairing confirm block: AES-128 constants and round functions.
// No dependencies.
package pc1_pkg;

  localparam int NumStages = 20;

  // APB byte addresses of the key halves
  localparam logic [3:0] AddrKeyLow  = 4'h0;
  localparam logic [3:0] AddrKeyHigh = 4'h8;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  typedef logic [127:0] block_t;

  // Byte i of the AES block is bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(block_t b, int i);
    return b[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One full round; the last round skips MixColumns.
  function automatic block_t aes_round(block_t st, block_t rk, logic last);
    block_t sr;
    block_t mc;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127-8*(c*4+r) -: 8] = SBOX[get_byte(st, ((c + r) % 4) * 4 + r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(sr, c*4);
      a1 = get_byte(sr, c*4+1);
      a2 = get_byte(sr, c*4+2);
      a3 = get_byte(sr, c*4+3);
      mc[127-8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      mc[127-8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      mc[127-8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      mc[127-8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return (last ? sr : mc) ^ rk;
  endfunction

  // Next round key from the previous one.
  function automatic block_t key_step(block_t k, logic [7:0] rc);
    logic [31:0] t;
    block_t n;
    t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    n[127:96] = k[127:96] ^ t;
    n[95:64]  = k[95:64] ^ n[127:96];
    n[63:32]  = k[63:32] ^ n[95:64];
    n[31:0]   = k[31:0] ^ n[63:32];
    return n;
  endfunction

endpackage

// ===== rtl/pc1_if.sv =====
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
interface pc1_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pairing_confirm_c1.sv =====
// Pairing confirm c1 = AES(k, AES(k, r ^ p1) ^ p2), fully unrolled.
// Uses pc1_pkg and pc1_if.
//
// Usage: the key is written through the APB port (key_low at 0x0, key_high at
// 0x8). Items enter on in_ch, a 338-bit beat packed {rand_low, rand_high,
// request_pdu, response_pdu, initiator_addr_type, responder_addr_type,
// initiator_addr, responder_addr}, first field in the top bits. Results leave
// on out_ch as {confirm_low, confirm_high}.
// Pipeline: twenty round stages (ten per AES pass), each one AES round, the
// first loaded at the accepting edge, then the output register that drives
// out_ch.valid. Throughput is one item per cycle unless the receiver stalls.
// Round keys 0 and 1 come straight from the key register; the rest sit in a
// register chain that settles one step a cycle, always ahead of the stage
// that needs them after a key write. Reset clears all stage valid bits and
// the key. When the receiver stalls with a result waiting in the output
// register the whole pipeline holds; ready into the block is low only while
// the output register is full and not being taken.
module pairing_confirm_c1
  import pc1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  pc1_if.sink         in_ch,
  pc1_if.source       out_ch
);

  logic [63:0] key_low;
  logic [63:0] key_high;
  block_t      rkey [11];
  block_t      rk_q [2:10];
  block_t      st   [NumStages];
  logic        vld  [NumStages];
  block_t      p2s  [10];
  logic        out_valid;
  block_t      out_data;
  logic        adv;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrKeyLow: key_low <= pwdata;
        AddrKeyHigh: key_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrKeyLow: prdata = key_low;
      AddrKeyHigh: prdata = key_high;
      default: prdata = '0;
    endcase
  end

  // The user must see that the key only changes while idle; the block does not
  // enforce it. The chain is then settled before any item needs a later round key.
  always_comb begin
    rkey[0] = {key_high, key_low};
    rkey[1] = key_step(rkey[0], RCON[0]);
    for (int i = 2; i < 11; i++) begin
      rkey[i] = rk_q[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 2; i < 11; i++) begin
      rk_q[i] <= key_step(rkey[i-1], RCON[i-1]);
    end
  end

  assign adv = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic [63:0] r_lo, r_hi, p1_lo, p1_hi;
  logic [55:0] preq, pres;
  logic [47:0] ia, ra;
  block_t      blk_in, p2_in, mid;

  always_comb begin
    r_lo  = in_ch.data[337:274];
    r_hi  = in_ch.data[273:210];
    preq  = in_ch.data[209:154];
    pres  = in_ch.data[153:98];
    ia    = in_ch.data[95:48];
    ra    = in_ch.data[47:0];
    p1_lo = {preq[47:0], 7'd0, in_ch.data[96], 7'd0, in_ch.data[97]};
    p1_hi = {pres, preq[55:48]};
    blk_in = {r_hi ^ p1_hi, r_lo ^ p1_lo} ^ rkey[0];
    p2_in  = {32'd0, ia, ra};
    mid    = st[9] ^ p2s[9] ^ rkey[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumStages; i++) vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_ch.valid;
      for (int i = 1; i < NumStages; i++) vld[i] <= vld[i-1];
      out_valid <= vld[NumStages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0]  <= aes_round(blk_in, rkey[1], 1'b0);
      p2s[0] <= p2_in;
      for (int i = 1; i < 10; i++) begin
        st[i]  <= aes_round(st[i-1], rkey[i+1], i == 9);
        p2s[i] <= p2s[i-1];
      end
      st[10] <= aes_round(mid, rkey[1], 1'b0);
      for (int i = 11; i < NumStages; i++) begin
        st[i] <= aes_round(st[i-1], rkey[i-9], i == NumStages-1);
      end
      out_data <= st[NumStages-1];
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = {out_data[63:0], out_data[127:64]};

endmodule

// ===== sim/pc1_checker.sv =====
// Scoreboard for pairing_confirm_c1: tracks the key from APB writes and
// predicts c1 for every accepted input beat. Compares output beats in order.
// Depends on pc1_pkg and pc1_if.
module pc1_checker
  import pc1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  pc1_if              in_ch,
  pc1_if              out_ch,
  output int          fail_count,
  output int          pending,
  output int          n_checked
);

  logic [7:0]   sbox [256];
  logic [63:0]  key_lo, key_hi;
  logic [127:0] confirm_q [$];

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  // S-box from the GF(2^8) inverse and the affine map
  initial begin
    logic [7:0] inv, bb, rot;
    for (int x = 0; x < 256; x++) begin
      inv = 8'd1;
      bb = x[7:0];
      for (int e = 0; e < 8; e++) begin
        if (e != 0) inv = gmul(inv, bb);
        bb = gmul(bb, bb);
      end
      rot = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox[x] = rot;
    end
  end

  function automatic logic [127:0] aes_enc(logic [127:0] key, logic [127:0] blk);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] t [4];
    logic [7:0] rcon, t0, a0, a1, a2, a3;
    logic [127:0] res;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = blk[127-8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        t0 = t[0];
        t[0] = sbox[t[1]] ^ rcon;
        t[1] = sbox[t[2]];
        t[2] = sbox[t[3]];
        t[3] = sbox[t0];
        rcon = gmul(rcon, 8'h02);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ t[j];
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int i = 0; i < 16; i++) st[i] = sbox[st[i]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) tmp[c*4+r] = st[((c+r)%4)*4+r];
      st = tmp;
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
          st[c*4]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
          st[c*4+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
          st[c*4+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
          st[c*4+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[rnd*16+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  // returns {confirm_high, confirm_low}
  function automatic logic [127:0] calc_confirm(logic [337:0] d);
    logic [127:0] key, r, p1, p2, c;
    key = {key_hi, key_lo};
    r   = {d[273:210], d[337:274]};
    p1  = {d[153:98], d[209:154], 7'b0, d[96], 7'b0, d[97]};
    p2  = {32'b0, d[95:48], d[47:0]};
    c   = aes_enc(key, r ^ p1);
    return aes_enc(key, c ^ p2);
  endfunction

  always @(posedge clk) begin
    logic [127:0] exp_c;
    if (rst) begin
      key_lo <= '0;
      key_hi <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) confirm_q.push_back(calc_confirm(in_ch.data));
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrKeyLow) key_lo <= pwdata;
        else if (paddr == AddrKeyHigh) key_hi <= pwdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (confirm_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", out_ch.data);
        end else begin
          exp_c = confirm_q.pop_front();
          if (out_ch.data[127:64] !== exp_c[63:0] || out_ch.data[63:0] !== exp_c[127:64]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("confirm mismatch: exp low %h high %h, got low %h high %h",
                       exp_c[63:0], exp_c[127:64], out_ch.data[127:64], out_ch.data[63:0]);
          end
        end
      end
    end
    pending = confirm_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    n_checked = 0;
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the pairing_confirm_c1 bench: clock, reset, APB key writes and
// valid/ready stimulus in several idle phases. Uses pc1_pkg, pc1_if and pc1_checker.
module testbench
  import pc1_pkg::*;
();

  localparam int RAND_PER_PHASE = 400;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;
  int          fails, pending, n_checked;
  int          tx_idle, rx_idle, hold_req, n_sent;

  pc1_if #(.W(338)) in_ch ();
  pc1_if #(.W(128)) out_ch ();

  pairing_confirm_c1 dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  pc1_checker chk (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fails), .pending(pending), .n_checked(n_checked)
  );

  always #10 clk = ~clk;

  initial begin
    #(20 * 400000);
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic key_write(logic [3:0] addr, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_beat(logic [337:0] d);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= d;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  function automatic logic [63:0] rnd64();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [337:0] rand_item();
    logic [337:0] d;
    logic [63:0]  w;
    d[337:274] = rnd64();
    d[273:210] = rnd64();
    w = rnd64();
    d[209:154] = w[55:0];
    w = rnd64();
    d[153:98]  = w[55:0];
    d[97]      = 1'($urandom_range(1));
    d[96]      = 1'($urandom_range(1));
    w = rnd64();
    d[95:48]   = w[47:0];
    w = rnd64();
    d[47:0]    = w[47:0];
    return d;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_beat(rand_item());
  endtask

  initial begin
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_ch.valid <= 1'b0; in_ch.data <= '0;
    tx_idle = 0; rx_idle = 0; hold_req = 0; n_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed beats on the reset key, then on an all-ones key
    send_beat('0);
    send_beat('1);
    send_beat({64'hffffffffffffffff, 274'b0});
    send_beat({64'b0, 64'hffffffffffffffff, 210'b0});
    send_beat({128'b0, 56'hffffffffffffff, 154'b0});
    send_beat({184'b0, 56'hffffffffffffff, 98'b0});
    send_beat({240'b0, 1'b1, 97'b0});
    send_beat({241'b0, 1'b1, 96'b0});
    send_beat({242'b0, 48'hffffffffffff, 48'b0});
    send_beat({290'b0, 48'hffffffffffff});
    send_beat({169{2'b10}});
    send_beat({169{2'b01}});
    drain();
    key_write(AddrKeyLow, '1);
    key_write(AddrKeyHigh, '1);
    send_beat('0);
    send_beat('1);
    send_beat({169{2'b10}});
    drain();

    tx_idle = 37; rx_idle = 63;
    key_write(AddrKeyLow, {$urandom, $urandom});
    key_write(AddrKeyHigh, {$urandom, $urandom});
    run_random(RAND_PER_PHASE);
    drain();

    tx_idle = 63; rx_idle = 37;
    key_write(AddrKeyLow, 64'h0);
    key_write(AddrKeyHigh, {$urandom, $urandom});
    run_random(RAND_PER_PHASE);
    drain();

    tx_idle = 0; rx_idle = 0;
    key_write(AddrKeyLow, {$urandom, $urandom});
    key_write(AddrKeyHigh, 64'h0);
    hold_req = 200;
    run_random(RAND_PER_PHASE);
    drain();

    $display("sent %0d beats over five key settings and three stall profiles,", n_sent);
    $display("including a long output hold-off; %0d results checked", n_checked);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pc1_pkg.sv
rtl/pc1_if.sv
rtl/pairing_confirm_c1.sv
sim/pc1_checker.sv
sim/testbench.sv
